// ----- hw/rtl/sbt_pkg.sv -----
`default_nettype none
package sbt_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

  typedef enum logic [4:0] {
    K_NEWLINE = 5'd0, K_IDENT = 5'd1, K_NUMBER = 5'd2, K_STRING = 5'd3,
    K_UNTERM = 5'd4, K_BADCHAR = 5'd5,
    K_LPAREN = 5'd6, K_RPAREN = 5'd7, K_LBRACE = 5'd8, K_RBRACE = 5'd9,
    K_LBRACK = 5'd10, K_RBRACK = 5'd11, K_COMMA = 5'd12, K_DOT = 5'd13,
    K_AT = 5'd14, K_SEMI = 5'd15, K_PLUS = 5'd16, K_MINUS = 5'd17,
    K_STAR = 5'd18, K_SLASH = 5'd19,
    K_BANG = 5'd20, K_NE = 5'd21, K_ASSIGN = 5'd22, K_EQ = 5'd23,
    K_LT = 5'd24, K_LE = 5'd25, K_GT = 5'd26, K_GE = 5'd27, K_EOF = 5'd28
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_HASH, M_SLASHC,
    M_BANG, M_EQ, M_LT, M_GT, M_SLASH
  } mode_t;

  typedef enum logic [2:0] {
    C_OTHER, C_SPACE, C_NEWLINE, C_ALPHA, C_DIGIT, C_QUOTE, C_PUNCT
  } cls_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [4:0]             token_kind;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] text_length;
    logic [7:0]             bad_char;
    logic                   last_result;
  } out_item_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_marker;
    cls_t       cls;
    logic [4:0] punct_kind;
  } cls_item_t;

  function automatic logic [4:0] punct_of(input logic [7:0] b);
    case (b)
      8'h28: punct_of = K_LPAREN;
      8'h29: punct_of = K_RPAREN;
      8'h7b: punct_of = K_LBRACE;
      8'h7d: punct_of = K_RBRACE;
      8'h5b: punct_of = K_LBRACK;
      8'h5d: punct_of = K_RBRACK;
      8'h2c: punct_of = K_COMMA;
      8'h2e: punct_of = K_DOT;
      8'h40: punct_of = K_AT;
      8'h3b: punct_of = K_SEMI;
      8'h2b: punct_of = K_PLUS;
      8'h2d: punct_of = K_MINUS;
      8'h2a: punct_of = K_STAR;
      default: punct_of = K_NEWLINE;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sbt_front.sv -----
`default_nettype none
module sbt_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  sbt_pkg::in_item_t     in_item,
  output logic                  q_valid,
  input  wire                   q_stall,
  output sbt_pkg::cls_item_t    q_item
);
  import sbt_pkg::*;

  cls_item_t cls_c;
  logic [7:0] b;

  always_comb begin
    b = in_item.char_byte;
    cls_c.char_byte  = b;
    cls_c.end_marker = in_item.end_marker;
    cls_c.punct_kind = punct_of(b);
    if (b == 8'h20 || b == 8'h09 || b == 8'h0d) cls_c.cls = C_SPACE;
    else if (b == 8'h0a) cls_c.cls = C_NEWLINE;
    else if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)) cls_c.cls = C_ALPHA;
    else if (b >= 8'h30 && b <= 8'h39) cls_c.cls = C_DIGIT;
    else if (b == 8'h22) cls_c.cls = C_QUOTE;
    else if (cls_c.punct_kind != K_NEWLINE) cls_c.cls = C_PUNCT;
    else cls_c.cls = C_OTHER;
  end

  assign in_stall = q_valid && q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (!in_stall && in_valid) q_item <= cls_c;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sbt_back.sv -----
`default_nettype none
module sbt_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  output logic                q_stall,
  input  sbt_pkg::cls_item_t  q_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output sbt_pkg::out_item_t  out_item
);
  import sbt_pkg::*;

  mode_t                  mode;
  logic [LINE_BITS-1:0]   line_cnt;
  logic [COLUMN_BITS-1:0] col_cnt;
  logic [OFFSET_BITS-1:0] byte_off;
  logic [COLUMN_BITS-1:0] tok_col;
  logic [OFFSET_BITS-1:0] tok_off;
  logic [OFFSET_BITS-1:0] tok_len;

  mode_t                  mode_next;
  logic [LINE_BITS-1:0]   line_next;
  logic [COLUMN_BITS-1:0] col_next;
  logic [OFFSET_BITS-1:0] off_next;
  logic [COLUMN_BITS-1:0] tcol_next;
  logic [OFFSET_BITS-1:0] toff_next;
  logic [OFFSET_BITS-1:0] tlen_next;

  // up to two results per item; a two-entry output buffer
  out_item_t r0, r1;
  logic      n0, n1;
  out_item_t buf0, buf1;
  logic [1:0] cnt;

  logic [OFFSET_BITS-1:0] off_inc, len_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic flushed, do_idle, fire;
  logic [7:0] b;
  cls_t c;

  function automatic out_item_t mk(input logic [4:0] k, input logic [LINE_BITS-1:0] ln,
                                   input logic [COLUMN_BITS-1:0] cl,
                                   input logic [OFFSET_BITS-1:0] of,
                                   input logic [OFFSET_BITS-1:0] ln2, input logic [7:0] bd);
    out_item_t r;
    r.token_kind = k; r.line_number = ln; r.column_number = cl;
    r.start_offset = of; r.text_length = ln2; r.bad_char = bd; r.last_result = 1'b0;
    return r;
  endfunction

  assign off_inc  = (byte_off == OFF_MAX) ? byte_off : byte_off + 1'b1;
  assign col_inc  = (col_cnt == COL_MAX) ? col_cnt : col_cnt + 1'b1;
  assign line_inc = (line_cnt == LINE_MAX) ? line_cnt : line_cnt + 1'b1;
  assign len_inc  = (tok_len == OFF_MAX) ? tok_len : tok_len + 1'b1;

  // accept only when buffer has room for two results
  assign q_stall = (cnt != 2'd0) && !(cnt == 2'd1 && !out_stall);
  assign fire = q_valid && !q_stall;
  assign b = q_item.char_byte;
  assign c = q_item.cls;

  always_comb begin
    mode_next = mode; line_next = line_cnt; col_next = col_cnt; off_next = byte_off;
    tcol_next = tok_col; toff_next = tok_off; tlen_next = tok_len;
    r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0;
    flushed = 1'b0; do_idle = 1'b0;

    // flush token of current mode into r0
    case (mode)
      M_IDENT:       r0 = mk(K_IDENT, line_cnt, tok_col, tok_off, tok_len, 8'd0);
      M_INT, M_FRAC: r0 = mk(K_NUMBER, line_cnt, tok_col, tok_off, tok_len, 8'd0);
      M_STR:         r0 = mk(K_UNTERM, line_cnt, tok_col, tok_off, tok_len, 8'd0);
      M_SLASH: r0 = mk(K_SLASH, line_cnt, tok_col, tok_off, OFFSET_BITS'(1), 8'd0);
      M_BANG:  r0 = mk(K_BANG, line_cnt, tok_col, tok_off, OFFSET_BITS'(1), 8'd0);
      M_EQ:    r0 = mk(K_ASSIGN, line_cnt, tok_col, tok_off, OFFSET_BITS'(1), 8'd0);
      M_LT:    r0 = mk(K_LT, line_cnt, tok_col, tok_off, OFFSET_BITS'(1), 8'd0);
      M_GT:    r0 = mk(K_GT, line_cnt, tok_col, tok_off, OFFSET_BITS'(1), 8'd0);
      default: r0 = '0;
    endcase
    flushed = (mode == M_IDENT || mode == M_INT || mode == M_FRAC || mode == M_STR ||
               mode == M_SLASH || mode == M_BANG || mode == M_EQ || mode == M_LT ||
               mode == M_GT);

    if (q_item.end_marker) begin
      n0 = flushed;
      r1 = mk(K_EOF, line_cnt, col_cnt, byte_off, '0, 8'd0);
      n1 = 1'b1;
      mode_next = M_IDLE; line_next = LINE_BITS'(1); col_next = COLUMN_BITS'(1);
      off_next = '0; tcol_next = COLUMN_BITS'(1); toff_next = '0; tlen_next = '0;
    end else begin
      case (mode)
        M_IDENT: begin
          if (c == C_ALPHA || c == C_DIGIT || b == 8'h5f) begin
            tlen_next = len_inc; off_next = off_inc; col_next = col_inc;
          end else begin
            n0 = 1'b1; do_idle = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (c == C_DIGIT) begin
            tlen_next = len_inc; off_next = off_inc; col_next = col_inc;
          end else if (mode == M_INT && b == 8'h2e) begin
            tlen_next = len_inc; off_next = off_inc; col_next = col_inc;
            mode_next = M_FRAC;
          end else begin
            n0 = 1'b1; do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (c == C_QUOTE) begin
            r0 = mk(K_STRING, line_cnt, tok_col, tok_off, tok_len, 8'd0);
            n0 = 1'b1; off_next = off_inc; col_next = col_inc; mode_next = M_IDLE;
          end else if (c != C_NEWLINE) begin
            tlen_next = len_inc; off_next = off_inc; col_next = col_inc;
          end else begin
            n0 = 1'b1; do_idle = 1'b1;
          end
        end
        M_HASH, M_SLASHC: begin
          if (c != C_NEWLINE) begin
            off_next = off_inc; col_next = col_inc;
          end else do_idle = 1'b1;
        end
        M_SLASH: begin
          if (b == 8'h2f) begin
            off_next = off_inc; col_next = col_inc; mode_next = M_SLASHC;
          end else begin
            n0 = 1'b1; do_idle = 1'b1;
          end
        end
        M_BANG, M_EQ, M_LT, M_GT: begin
          if (b == 8'h3d) begin
            r0.token_kind = r0.token_kind + 5'd1;
            r0.text_length = OFFSET_BITS'(2);
            n0 = 1'b1; off_next = off_inc; col_next = col_inc; mode_next = M_IDLE;
          end else begin
            n0 = 1'b1; do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next = M_IDLE;
        if (c == C_SPACE) begin
          off_next = off_inc; col_next = col_inc;
        end else if (c == C_NEWLINE) begin
          r1 = mk(K_NEWLINE, line_cnt, col_cnt, byte_off, OFFSET_BITS'(1), 8'd0); n1 = 1'b1;
          off_next = off_inc; line_next = line_inc; col_next = COLUMN_BITS'(1);
        end else if (b == 8'h23) begin
          off_next = off_inc; col_next = col_inc; mode_next = M_HASH;
        end else if (c == C_QUOTE) begin
          tcol_next = col_cnt; off_next = off_inc; col_next = col_inc;
          toff_next = off_inc; tlen_next = '0; mode_next = M_STR;
        end else if (c == C_ALPHA || c == C_DIGIT || b == 8'h5f || b == 8'h2f ||
                     b == 8'h21 || b == 8'h3d || b == 8'h3c || b == 8'h3e) begin
          tcol_next = col_cnt; toff_next = byte_off; tlen_next = OFFSET_BITS'(1);
          off_next = off_inc; col_next = col_inc;
          if (c == C_DIGIT) mode_next = M_INT;
          else if (b == 8'h2f) mode_next = M_SLASH;
          else if (b == 8'h21) mode_next = M_BANG;
          else if (b == 8'h3d) mode_next = M_EQ;
          else if (b == 8'h3c) mode_next = M_LT;
          else if (b == 8'h3e) mode_next = M_GT;
          else mode_next = M_IDENT;
        end else if (c == C_PUNCT) begin
          r1 = mk(q_item.punct_kind, line_cnt, col_cnt, byte_off, OFFSET_BITS'(1), 8'd0);
          n1 = 1'b1; off_next = off_inc; col_next = col_inc;
        end else begin
          r1 = mk(K_BADCHAR, line_cnt, col_cnt, byte_off, OFFSET_BITS'(1), b);
          n1 = 1'b1; off_next = off_inc; col_next = col_inc;
        end
      end
    end

    if (n1) r1.last_result = 1'b1;
    else r0.last_result = 1'b1;
  end

  assign out_valid = (cnt != 2'd0);
  assign out_item  = buf0;

  always_ff @(posedge clk) begin
    logic pop;
    logic [1:0] left;
    pop = out_valid && !out_stall;
    left = cnt - {1'b0, pop};
    if (rst) begin
      cnt <= 2'd0;
      mode <= M_IDLE;
      line_cnt <= LINE_BITS'(1);
      col_cnt <= COLUMN_BITS'(1);
      byte_off <= '0;
      tok_col <= COLUMN_BITS'(1);
      tok_off <= '0;
      tok_len <= '0;
    end else begin
      if (pop && cnt == 2'd2) buf0 <= buf1;
      if (fire) begin
        mode <= mode_next; line_cnt <= line_next; col_cnt <= col_next;
        byte_off <= off_next; tok_col <= tcol_next; tok_off <= toff_next;
        tok_len <= tlen_next;
        // left is 0 here
        if (n0) begin
          buf0 <= r0;
          if (n1) buf1 <= r1;
        end else if (n1) begin
          buf0 <= r1;
        end
        cnt <= left + {1'b0, n0} + {1'b0, n1};
      end else begin
        cnt <= left;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/source_byte_tokenizer_core.sv -----
// Bytes pass through the classify stage, then the scan stage, which writes tokens to the output buffer.
// One byte per cycle while each byte yields at most one token and out_stall is low;
// a byte that yields two tokens holds input while the two-entry output buffer drains.
// Reset (rst, synchronous): scanner idle, line 1, column 1, offset 0, buffers empty.
`default_nettype none
module source_byte_tokenizer_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sbt_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sbt_pkg::out_item_t   out_item
);
  import sbt_pkg::*;

  logic      q_valid, q_stall;
  cls_item_t q_item;

  sbt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
  );

  sbt_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

endmodule
`default_nettype wire
